// ----- rtl/core/lhb_pkg.sv -----
package lhb_pkg;

  localparam int FUNC_W    = 2;
  localparam int SAMPLE_W  = 40;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 48;
  localparam int SUM_W     = 64;
  localparam int WIDTH_W   = 40;
  localparam int OFFSET_W  = 16;
  localparam int NBINS_W   = 10;
  localparam int CFG_IDX_W = 2;

  // Divider width: one bit more than a sample; the quotient of a sample by the bin width, rounded half up, fits in it.
  localparam int DIV_W = SAMPLE_W + 1;

  localparam int MAX_BINS_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF    = 40;
  localparam int BIN_COUNT_BITS_DEF = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_MEDIAN = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH  = 2'd0,
    REG_BIN_OFFSET = 2'd1,
    REG_NUM_BINS   = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

endpackage

// ----- rtl/core/lhb_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
module lhb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lhb_pkg::div_req_t req,
  output lhb_pkg::div_rsp_t rsp
);

  localparam int DW = lhb_pkg::DIV_W;
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- rtl/core/latency_histogram_binner.sv -----
// Latency histogram with running statistics.
// The input channel carries one request per item: func 0 records a sample,
// func 1 reads the bin at bin_index, func 2 reports the median bin, func 3
// changes nothing. Every request yields exactly one result that carries the
// value plus all running statistics as they stand after the request.
// Both channels use valid and stall; the configuration channel writes
// bin_width, bin_offset and num_bins and must only be used while idle.
// A sample takes one serial division (one quotient bit per cycle in the
// shared divider) and then a bin update; one that falls below the offset
// skips the update, and one that lands past the last bin needs a second
// division. A median query walks the bin memory one bin per cycle through
// its single read port.
// One request is in work at a time; a new one is accepted as soon as the
// previous result is placed in the output register, even if it is stalled.
// After reset the bin memory is cleared one entry per cycle while in_stall
// stays high. A stalled result holds in the output register;
// work on the next request continues and waits only to hand its result over.
module latency_histogram_binner #(
  parameter int MAX_BINS       = lhb_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS    = lhb_pkg::SAMPLE_BITS_DEF,
  parameter int BIN_COUNT_BITS = lhb_pkg::BIN_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lhb_pkg::FUNC_W-1:0]      in_func,
  input  logic [lhb_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [lhb_pkg::INDEX_W-1:0]     in_bin_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lhb_pkg::VALUE_W-1:0]     out_value,
  output logic [lhb_pkg::COUNT_W-1:0]     out_sample_count,
  output logic [lhb_pkg::SUM_W-1:0]       out_sample_sum,
  output logic [lhb_pkg::SAMPLE_W-1:0]    out_min_sample,
  output logic [lhb_pkg::SAMPLE_W-1:0]    out_max_sample,
  output logic [lhb_pkg::COUNT_W-1:0]     out_underflow_count,
  output logic [lhb_pkg::COUNT_W-1:0]     out_overflow_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lhb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhb_pkg::WIDTH_W-1:0]     cfg_data
);

  localparam int DW  = lhb_pkg::DIV_W;
  localparam int SW  = lhb_pkg::SAMPLE_W;
  localparam int CNW = lhb_pkg::COUNT_W;
  localparam int SMW = lhb_pkg::SUM_W;
  localparam int VW  = lhb_pkg::VALUE_W;
  localparam int IW  = $clog2(MAX_BINS);
  localparam int TW  = ($clog2(MAX_BINS + 1) > lhb_pkg::NBINS_W + 1) ?
                       $clog2(MAX_BINS + 1) : lhb_pkg::NBINS_W + 1;
  localparam int BW  = BIN_COUNT_BITS;
  localparam int AW  = ((BW > DW) ? BW : DW) + 1;
  localparam logic [SW-1:0] SMASK = (SAMPLE_BITS >= SW) ? {SW{1'b1}} :
                                    SW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [BW-1:0] BLIM  = {BW{1'b1}};

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DIV1   = 9'b000000100,
    S_BIN    = 9'b000001000,
    S_DIV2   = 9'b000010000,
    S_RDWAIT = 9'b000100000,
    S_RMW    = 9'b001000000,
    S_MED    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  // Configuration registers.
  logic [lhb_pkg::WIDTH_W-1:0]  bin_width_r;
  logic [lhb_pkg::OFFSET_W-1:0] bin_offset_r;
  logic [lhb_pkg::NBINS_W-1:0]  num_bins_r;

  // Control and running statistics.
  state_t         state_r, state_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic [SW-1:0]  min_r, min_nxt;
  logic [SW-1:0]  max_r, max_nxt;
  logic [SMW-1:0] sum_r, sum_nxt;
  logic [CNW-1:0] recorded_r, recorded_nxt;
  logic [CNW-1:0] below_r, below_nxt;
  logic [CNW-1:0] above_r, above_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Working registers of the request in flight.
  logic [DW-1:0]  bin_r, bin_nxt;
  logic [DW-1:0]  den_r, den_nxt;
  logic [DW-1:0]  amt_r, amt_nxt;
  logic [IW-1:0]  addr_r, addr_nxt;
  logic [CNW-1:0] half_r, half_nxt;
  logic [SMW-1:0] acc_r, acc_nxt;
  logic [IW-1:0]  med_i_r, med_i_nxt;
  logic [VW-1:0]  value_r, value_nxt;

  // Output payload.
  logic [VW-1:0]  o_value_r;
  logic [CNW-1:0] o_count_r;
  logic [SMW-1:0] o_sum_r;
  logic [SW-1:0]  o_min_r;
  logic [SW-1:0]  o_max_r;
  logic [CNW-1:0] o_under_r;
  logic [CNW-1:0] o_over_r;
  logic           o_load;

  // Bin memory.
  logic [BW-1:0]  bins_mem [MAX_BINS];
  logic [BW-1:0]  rd_data_r;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [BW-1:0]  wr_data;

  lhb_pkg::div_req_t div_req;
  lhb_pkg::div_rsp_t div_rsp;

  logic [TW-1:0]  nb_plus;
  logic [TW-1:0]  total;
  logic [SW-1:0]  s_m;
  logic [DW-1:0]  gap;
  logic [DW-1:0]  round_q;
  logic [DW-1:0]  bin_diff;
  logic [AW-1:0]  bin_sum;
  logic [BW-1:0]  bin_sat;
  logic [SMW:0]   acc_sum;
  logic [SMW-1:0] acc_sat;

  assign nb_plus = TW'(num_bins_r) + TW'(1);
  assign total   = (nb_plus > TW'(MAX_BINS)) ? TW'(MAX_BINS) : nb_plus;
  assign s_m     = in_sample & SMASK;

  // Round half up: bump the quotient when the remainder is at least half the divisor.
  assign gap     = den_r - div_rsp.rem;
  assign round_q = div_rsp.quo + DW'(div_rsp.rem >= gap);

  assign bin_diff = bin_r - DW'(bin_offset_r);
  assign bin_sum  = AW'(rd_data_r) + AW'(amt_r);
  assign bin_sat  = (bin_sum > AW'(BLIM)) ? BLIM : bin_sum[BW-1:0];
  assign acc_sum  = {1'b0, acc_r} + (SMW + 1)'(rd_data_r);
  assign acc_sat  = acc_sum[SMW] ? {SMW{1'b1}} : acc_sum[SMW-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  lhb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r  <= lhb_pkg::WIDTH_W'(1);
      bin_offset_r <= '0;
      num_bins_r   <= lhb_pkg::NBINS_W'(1023);
    end else if (cfg_valid) begin
      case (lhb_pkg::cfg_reg_t'(cfg_index))
        lhb_pkg::REG_BIN_WIDTH:  bin_width_r  <= cfg_data;
        lhb_pkg::REG_BIN_OFFSET: bin_offset_r <= cfg_data[lhb_pkg::OFFSET_W-1:0];
        lhb_pkg::REG_NUM_BINS:   num_bins_r   <= cfg_data[lhb_pkg::NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    recorded_nxt  = recorded_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    out_valid_nxt = out_valid_r & out_stall;
    bin_nxt       = bin_r;
    den_nxt       = den_r;
    amt_nxt       = amt_r;
    addr_nxt      = addr_r;
    half_nxt      = half_r;
    acc_nxt       = acc_r;
    med_i_nxt     = med_i_r;
    value_nxt     = value_r;
    div_req       = '0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = bin_sat;
    o_load        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          value_nxt = '0;
          case (lhb_pkg::func_t'(in_func))
            lhb_pkg::FUNC_RECORD: begin
              if (s_m > max_r) max_nxt = s_m;
              if (s_m < min_r) min_nxt = s_m;
              sum_nxt       = sum_r + SMW'(s_m);
              recorded_nxt  = recorded_r + CNW'(1);
              den_nxt       = (bin_width_r == '0) ? DW'(1) : DW'(bin_width_r);
              div_req.start = 1'b1;
              div_req.num   = DW'(s_m);
              div_req.den   = den_nxt;
              state_nxt     = S_DIV1;
            end
            lhb_pkg::FUNC_READ: begin
              if (TW'(in_bin_index) < total) begin
                rd_en     = 1'b1;
                rd_addr   = IW'(in_bin_index);
                state_nxt = S_RDWAIT;
              end else begin
                state_nxt = S_FIN;
              end
            end
            lhb_pkg::FUNC_MEDIAN: begin
              half_nxt  = recorded_r >> 1;
              acc_nxt   = '0;
              med_i_nxt = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_MED;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          bin_nxt   = round_q;
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        if (bin_r < DW'(bin_offset_r)) begin
          below_nxt = below_r + CNW'(1);
          state_nxt = S_FIN;
        end else if (bin_diff < DW'(total)) begin
          amt_nxt   = DW'(1);
          addr_nxt  = IW'(bin_diff);
          rd_en     = 1'b1;
          rd_addr   = IW'(bin_diff);
          state_nxt = S_RMW;
        end else begin
          // Past the last bin: its weight, scaled by the bins in use, goes to the last bin.
          above_nxt     = above_r + CNW'(1);
          den_nxt       = DW'(total);
          div_req.start = 1'b1;
          div_req.num   = bin_diff;
          div_req.den   = DW'(total);
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          amt_nxt   = round_q;
          addr_nxt  = IW'(total - TW'(1));
          rd_en     = 1'b1;
          rd_addr   = IW'(total - TW'(1));
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        wr_en     = 1'b1;
        state_nxt = S_FIN;
      end
      S_RDWAIT: begin
        value_nxt = VW'(rd_data_r);
        state_nxt = S_FIN;
      end
      S_MED: begin
        acc_nxt = acc_sat;
        if (acc_sat >= SMW'(half_r)) begin
          value_nxt = VW'(med_i_r);
          state_nxt = S_FIN;
        end else if (TW'(med_i_r) == total - TW'(1)) begin
          value_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          med_i_nxt = med_i_r + IW'(1);
          rd_en     = 1'b1;
          rd_addr   = med_i_r + IW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          o_load        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      min_r       <= SMASK;
      max_r       <= '0;
      sum_r       <= '0;
      recorded_r  <= '0;
      below_r     <= '0;
      above_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      recorded_r  <= recorded_nxt;
      below_r     <= below_nxt;
      above_r     <= above_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    den_r   <= den_nxt;
    amt_r   <= amt_nxt;
    addr_r  <= addr_nxt;
    half_r  <= half_nxt;
    acc_r   <= acc_nxt;
    med_i_r <= med_i_nxt;
    value_r <= value_nxt;
    if (o_load) begin
      o_value_r <= value_r;
      o_count_r <= recorded_r;
      o_sum_r   <= sum_r;
      o_min_r   <= min_r;
      o_max_r   <= max_r;
      o_under_r <= below_r;
      o_over_r  <= above_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bins_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bins_mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_value           = o_value_r;
  assign out_sample_count    = o_count_r;
  assign out_sample_sum      = o_sum_r;
  assign out_min_sample      = o_min_r;
  assign out_max_sample      = o_max_r;
  assign out_underflow_count = o_under_r;
  assign out_overflow_count  = o_over_r;

`ifndef SYNTHESIS
  a_record_counts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == lhb_pkg::FUNC_RECORD)
      |=> recorded_r == $past(recorded_r) + CNW'(1))
    else $error("sample count did not advance on a record request");

  a_div_start : assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == S_IDLE || state_r == S_BIN))
    else $error("divider started outside a record request");

  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result appeared without finishing a request");

  a_bin_write_range : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_RMW) |-> TW'(wr_addr) < total)
    else $error("bin update outside the bins in use");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the latency histogram binner.
// Requests are driven at the falling clock edge and results are sampled at
// the rising edge. A predictor inside this module keeps its own copy of the
// bins, the running statistics and the registers. Each accepted request is
// predicted at once and queued. The result monitor compares every result
// with the oldest queued prediction, field by field.
module tb_top;
  import lhb_pkg::*;

  // One result as the block reports it.
  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min_s;
    logic [SAMPLE_W-1:0] max_s;
    logic [COUNT_W-1:0]  under;
    logic [COUNT_W-1:0]  over;
  } hist_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic [INDEX_W-1:0]  in_bin_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_W-1:0]  out_sample_count;
  logic [SUM_W-1:0]    out_sample_sum;
  logic [SAMPLE_W-1:0] out_min_sample;
  logic [SAMPLE_W-1:0] out_max_sample;
  logic [COUNT_W-1:0]  out_underflow_count;
  logic [COUNT_W-1:0]  out_overflow_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]  cfg_data = '0;

  latency_histogram_binner uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_sample(in_sample), .in_bin_index(in_bin_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_sample_count(out_sample_count),
    .out_sample_sum(out_sample_sum), .out_min_sample(out_min_sample),
    .out_max_sample(out_max_sample), .out_underflow_count(out_underflow_count),
    .out_overflow_count(out_overflow_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is ended here if the block stops answering. A median request
  // walks at most about a thousand bins, so even a run made only of those,
  // with every result stalled, stays far below this limit.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Predictor state: registers and the histogram as they should be.
  logic [WIDTH_W-1:0]  width_reg;
  logic [OFFSET_W-1:0] offset_reg;
  logic [NBINS_W-1:0]  nbins_reg;
  logic [31:0]         bin_tally [MAX_BINS_DEF];
  logic [SAMPLE_W-1:0] seen_min;
  logic [SAMPLE_W-1:0] seen_max;
  logic [SUM_W-1:0]    seen_sum;
  logic [COUNT_W-1:0]  seen_count;
  logic [COUNT_W-1:0]  under_tally;
  logic [COUNT_W-1:0]  over_tally;

  hist_result_t expected_results[$];
  int unsigned  mismatches = 0;

  // Idle rates in percent for the two sides, and a long receiver hold-off.
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_off_cycles = 0;

  // Division rounded half up; a zero divisor counts as one.
  function automatic longint unsigned div_half_up(longint unsigned num,
                                                  longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    if (den == 0) den = 1;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return q;
  endfunction

  // Adds weight to one bin, saturating at the bin's full scale.
  function automatic void bump_bin(int unsigned idx, longint unsigned amount);
    longint unsigned cur;
    cur = bin_tally[idx];
    if (amount > 64'hFFFF_FFFF - cur) bin_tally[idx] = 32'hFFFF_FFFF;
    else bin_tally[idx] = cur + amount;
  endfunction

  function automatic int unsigned bins_active();
    return int'(nbins_reg) + 1;
  endfunction

  // Works out the result of one request and updates the predicted state.
  function automatic hist_result_t predict_histogram(func_t f,
      logic [SAMPLE_W-1:0] s, logic [INDEX_W-1:0] idx);
    hist_result_t    res;
    longint unsigned bin;
    longint unsigned half;
    longint unsigned acc;
    int unsigned     total;
    total = bins_active();
    res.value = '0;
    case (f)
      FUNC_RECORD: begin
        if (s > seen_max) seen_max = s;
        if (s < seen_min) seen_min = s;
        seen_sum = seen_sum + s;
        seen_count = seen_count + 1;
        bin = div_half_up(s, width_reg);
        if (bin < offset_reg) begin
          under_tally = under_tally + 1;
        end else begin
          bin = bin - offset_reg;
          if (bin < total) begin
            bump_bin(bin, 1);
          end else begin
            // Past the last bin: the last bin takes the scaled weight.
            over_tally = over_tally + 1;
            bump_bin(total - 1, div_half_up(bin, total));
          end
        end
      end
      FUNC_READ: begin
        if (idx < total) res.value = bin_tally[idx];
      end
      FUNC_MEDIAN: begin
        // The first bin where the running total reaches half the samples;
        // zero if it is never reached.
        half = seen_count / 2;
        acc = 0;
        for (int unsigned i = 0; i < total; i++) begin
          if (bin_tally[i] > ~64'd0 - acc) acc = ~64'd0;
          else acc = acc + bin_tally[i];
          if (acc >= half) begin
            res.value = i;
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = seen_count;
    res.sum   = seen_sum;
    res.min_s = seen_min;
    res.max_s = seen_max;
    res.under = under_tally;
    res.over  = over_tally;
    return res;
  endfunction

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void compare_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10)
        $display("Mismatch in %s: expected %0h, got %0h at %0t",
                 name, exp_v, act_v, $realtime);
      mismatches++;
    end
  endfunction

  // Result monitor: every accepted result is matched against the oldest
  // prediction still waiting.
  always @(posedge clk) begin
    hist_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("Result with no request waiting at %0t", $realtime);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("value", exp_r.value, out_value);
        compare_field("sample_count", exp_r.count, out_sample_count);
        compare_field("sample_sum", exp_r.sum, out_sample_sum);
        compare_field("min_sample", exp_r.min_s, out_min_sample);
        compare_field("max_sample", exp_r.max_s, out_max_sample);
        compare_field("underflow_count", exp_r.under, out_underflow_count);
        compare_field("overflow_count", exp_r.over, out_overflow_count);
      end
    end
  end

  // Sends one request and predicts its result once the block takes it.
  task automatic send_request(func_t f, logic [SAMPLE_W-1:0] s,
                              logic [INDEX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 4)) @(negedge clk);
    in_func = f;
    in_sample = s;
    in_bin_index = idx;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), predict_histogram(f, s, idx));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every predicted result has come back, then a short margin.
  task automatic wait_for_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(cfg_reg_t r, logic [WIDTH_W-1:0] data);
    cfg_index = r;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_BIN_WIDTH:  width_reg = data;
      REG_BIN_OFFSET: offset_reg = data[OFFSET_W-1:0];
      REG_NUM_BINS:   nbins_reg = data[NBINS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic [WIDTH_W-1:0] w, logic [OFFSET_W-1:0] off,
                            logic [NBINS_W-1:0] nb);
    wait_for_idle();
    write_reg(REG_BIN_WIDTH, w);
    write_reg(REG_BIN_OFFSET, off);
    write_reg(REG_NUM_BINS, nb);
  endtask

  // Extremes of the fields at the reset settings: a sample of zero, the
  // largest sample repeated until the last bin saturates, reads of the first
  // and the last bin, a median and the unused function code.
  task automatic test_reset_defaults();
    send_request(FUNC_READ, '0, 10'd0);
    send_request(FUNC_MEDIAN, '0, '0);
    send_request(FUNC_RECORD, '0, '0);
    send_request(FUNC_RECORD, 40'd1, '0);
    repeat (5) send_request(FUNC_RECORD, '1, '0);
    send_request(FUNC_READ, '0, 10'd1023);
    send_request(FUNC_READ, '0, 10'd0);
    send_request(FUNC_MEDIAN, '0, '0);
    send_request(FUNC_NONE, '1, '1);
  endtask

  // Register extremes: a zero width, the largest offset, a single bin,
  // then the widest bins with the largest bin count.
  task automatic test_register_extremes();
    set_config('0, 16'hFFFF, '0);
    write_reg(REG_UNUSED, '1);
    send_request(FUNC_RECORD, 40'd65534, '0);
    send_request(FUNC_RECORD, 40'd65535, '0);
    send_request(FUNC_RECORD, 40'd65536, '0);
    send_request(FUNC_READ, '0, 10'd0);
    send_request(FUNC_READ, '0, 10'd1);
    send_request(FUNC_MEDIAN, '0, '0);
    set_config('1, '0, 10'd1023);
    send_request(FUNC_RECORD, 40'h80_0000_0000, '0);
    send_request(FUNC_RECORD, 40'h7F_FFFF_FFFF, '0);
    send_request(FUNC_READ, '0, 10'd1);
    send_request(FUNC_MEDIAN, '0, '0);
  endtask

  // A random sample, mostly aimed at a bin near the used range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint unsigned w;
    longint unsigned target;
    w = (width_reg == 0) ? 1 : width_reg;
    case ($urandom_range(19))
      0, 1: return {$urandom, $urandom};
      2: return '1;
      3: return '0;
      default: begin
        target = $urandom_range(offset_reg + nbins_reg + 4);
        if (target > 0 && $urandom_range(1)) target--;
        return target * w + ({$urandom, $urandom} % w);
      end
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned n);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 62) send_request(FUNC_RECORD, pick_sample(), '0);
      else if (pick < 86) send_request(FUNC_READ, {$urandom, $urandom},
                                       $urandom_range(nbins_reg + 3 > 1023 ? 1023
                                                      : nbins_reg + 3));
      else if (pick < 96) send_request(FUNC_MEDIAN, {$urandom, $urandom}, $urandom);
      else send_request(FUNC_NONE, {$urandom, $urandom}, $urandom);
    end
  endtask

  // One random register setting; small bins and widths dominate.
  task automatic random_config();
    logic [WIDTH_W-1:0]  w;
    logic [OFFSET_W-1:0] off;
    logic [NBINS_W-1:0]  nb;
    case ($urandom_range(4))
      0: w = $urandom_range(1, 8);
      1: w = $urandom_range(1, 1000);
      2: w = {$urandom_range(255), $urandom} >> $urandom_range(39);
      3: w = 0;
      default: w = $urandom_range(1, 1 << 20);
    endcase
    off = ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
    nb = ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(40);
    set_config(w, off, nb);
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block fills up and stalls its input; then the sender pauses
  // until every result is back.
  task automatic test_backpressure();
    set_config(40'd3, 16'd2, 10'd15);
    hold_off_cycles = 600;
    test_random_traffic(40);
    wait_for_idle();
    test_random_traffic(40);
  endtask

  initial begin
    width_reg = 1;
    offset_reg = 0;
    nbins_reg = 1023;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    seen_min = '1;
    seen_max = '0;
    seen_sum = '0;
    seen_count = '0;
    under_tally = '0;
    over_tally = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_extremes();

    send_idle_pct = 21;
    recv_stall_pct = 58;
    for (int p = 0; p < 2; p++) begin
      random_config();
      test_random_traffic(225);
    end
    send_idle_pct = 58;
    recv_stall_pct = 21;
    for (int p = 0; p < 2; p++) begin
      random_config();
      test_random_traffic(225);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int p = 0; p < 2; p++) begin
      random_config();
      test_random_traffic(225);
    end
    test_backpressure();

    wait_for_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
